### rtl/core/status_led_fade_and_blink_code_unit_defines.svh
// assertion macros for the checker file
`ifndef STATUS_LED_FADE_AND_BLINK_CODE_UNIT_DEFINES_SVH
`define STATUS_LED_FADE_AND_BLINK_CODE_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define SLFBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slfbc check failed");

// next-cycle implication, off while reset is high
`define SLFBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slfbc check failed");

// next-cycle implication that also watches reset itself
`define SLFBC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("slfbc check failed");

`endif

### rtl/core/slfbc_pkg.sv
package slfbc_pkg;

   // time stamp arithmetic width, differences wrap at this width
   localparam int TIME_BITS      = 32;
   localparam int STAMP_BITS     = 32;
   localparam int WIDE_BITS      = 64;
   localparam int STEP_BITS      = 16;
   localparam int TOGGLE_BITS    = 16;
   localparam int LEVEL_BITS     = 8;
   localparam int CODE_BITS      = 8;
   localparam int NIBBLE_BITS    = 4;
   localparam int COUNT_BITS     = 5;
   // toggle_time * 8, doubled for the long gap
   localparam int GAP_BITS       = TOGGLE_BITS + 4;
   localparam int CMP_BITS       = (TIME_BITS > GAP_BITS) ? TIME_BITS : GAP_BITS;

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 4;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_STEP_TIME      = 2'd0;
   localparam reg_index_type REG_MAX_BRIGHTNESS = 2'd1;
   localparam reg_index_type REG_BLINK_CODE     = 2'd2;
   localparam reg_index_type REG_TOGGLE_TIME    = 2'd3;

   localparam logic [STEP_BITS-1:0]   STEP_TIME_RESET      = STEP_BITS'(1000);
   localparam logic [LEVEL_BITS-1:0]  MAX_BRIGHTNESS_RESET = LEVEL_BITS'(255);
   localparam logic [CODE_BITS-1:0]   BLINK_CODE_RESET     = '0;
   localparam logic [TOGGLE_BITS-1:0] TOGGLE_TIME_RESET    = TOGGLE_BITS'(2500);

   typedef struct packed {
      logic [STEP_BITS-1:0]   step_time;
      logic [LEVEL_BITS-1:0]  max_brightness;
      logic [CODE_BITS-1:0]   blink_code;
      logic [TOGGLE_BITS-1:0] toggle_time;
   } cfg_type;

endpackage

### rtl/core/slfbc_ramp.sv
module slfbc_ramp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [slfbc_pkg::TIME_BITS-1:0]   now,
   input  slfbc_pkg::cfg_type                cfg,
   output logic [slfbc_pkg::LEVEL_BITS-1:0]  level,
   output logic                              stepped
);

   logic [slfbc_pkg::TIME_BITS-1:0]  step_mark_ff, step_mark_in;
   logic [slfbc_pkg::LEVEL_BITS-1:0] brightness_ff, brightness_in;
   logic                             falling_ff, falling_in;

   logic [slfbc_pkg::TIME_BITS-1:0]  elapsed;
   logic                             step_due;
   logic signed [slfbc_pkg::LEVEL_BITS+1:0] base;
   logic signed [slfbc_pkg::LEVEL_BITS+1:0] top;
   logic signed [slfbc_pkg::LEVEL_BITS+1:0] want;
   logic                             want_falling;

   assign elapsed  = now - step_mark_ff;
   assign step_due = slfbc_pkg::CMP_BITS'(elapsed) > slfbc_pkg::CMP_BITS'(cfg.step_time);

   always_comb begin
      base = $signed({2'b00, brightness_ff});
      top  = $signed({2'b00, cfg.max_brightness});
      want = falling_ff ? base - 10'sd1 : base + 10'sd1;
      want_falling = falling_ff;
      // clamp at the top first, then at zero
      if (want >= top) begin
         want         = top;
         want_falling = 1'b1;
      end
      if (want <= 10'sd0) begin
         want         = 10'sd0;
         want_falling = 1'b0;
      end

      step_mark_in  = step_mark_ff;
      brightness_in = brightness_ff;
      falling_in    = falling_ff;
      if (step_due) begin
         step_mark_in  = now;
         brightness_in = want[slfbc_pkg::LEVEL_BITS-1:0];
         falling_in    = want_falling;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_mark_ff  <= '0;
         brightness_ff <= '0;
         falling_ff    <= 1'b0;
      end else if (advance) begin
         step_mark_ff  <= step_mark_in;
         brightness_ff <= brightness_in;
         falling_ff    <= falling_in;
      end
   end

   assign level   = brightness_in;
   assign stepped = step_due;

endmodule

### rtl/core/slfbc_blink.sv
module slfbc_blink (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [slfbc_pkg::TIME_BITS-1:0]  now,
   input  slfbc_pkg::cfg_type               cfg,
   output logic                             active,
   output logic                             blink_level
);

   logic [slfbc_pkg::TIME_BITS-1:0]  toggle_mark_ff, toggle_mark_in;
   logic [slfbc_pkg::COUNT_BITS-1:0] toggle_count_ff, toggle_count_in;
   logic                             upper_ff, upper_in;

   logic [slfbc_pkg::NIBBLE_BITS-1:0] lo_nib, hi_nib, nib;
   logic                              upper_eff;
   logic [slfbc_pkg::TIME_BITS-1:0]   elapsed;
   logic [slfbc_pkg::GAP_BITS-1:0]    gap;
   logic                              in_burst;

   assign lo_nib  = cfg.blink_code[slfbc_pkg::NIBBLE_BITS-1:0];
   assign hi_nib  = cfg.blink_code[slfbc_pkg::CODE_BITS-1:slfbc_pkg::NIBBLE_BITS];
   assign active  = (cfg.blink_code != '0);
   assign elapsed = now - toggle_mark_ff;

   always_comb begin
      // a single set nibble forces its own half
      upper_eff = upper_ff;
      if (lo_nib != '0 && hi_nib != '0) begin
         upper_eff = upper_ff;
      end else if (lo_nib != '0) begin
         upper_eff = 1'b0;
      end else if (hi_nib != '0) begin
         upper_eff = 1'b1;
      end
      nib = upper_eff ? hi_nib : lo_nib;
      // long gap after the high nibble, short gap after the low one
      gap = upper_eff ? {cfg.toggle_time, 4'b0000} : {1'b0, cfg.toggle_time, 3'b000};
      in_burst = toggle_count_ff[slfbc_pkg::COUNT_BITS-1:1] < nib;

      toggle_mark_in  = toggle_mark_ff;
      toggle_count_in = toggle_count_ff;
      upper_in        = upper_eff;
      if (in_burst) begin
         if (slfbc_pkg::CMP_BITS'(elapsed) > slfbc_pkg::CMP_BITS'(cfg.toggle_time)) begin
            toggle_mark_in  = now;
            toggle_count_in = toggle_count_ff + 5'd1;
         end
      end else if (slfbc_pkg::CMP_BITS'(elapsed) > slfbc_pkg::CMP_BITS'(gap)) begin
         toggle_mark_in  = now;
         toggle_count_in = '0;
         upper_in        = ~upper_eff;
      end
   end

   // engine is frozen while no code is set
   always_ff @(posedge clock) begin
      if (reset) begin
         toggle_mark_ff  <= '0;
         toggle_count_ff <= '0;
         upper_ff        <= 1'b0;
      end else if (advance && active) begin
         toggle_mark_ff  <= toggle_mark_in;
         toggle_count_ff <= toggle_count_in;
         upper_ff        <= upper_in;
      end
   end

   assign blink_level = active & ~toggle_count_in[0];

endmodule

### rtl/core/status_led_fade_and_blink_code_unit.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_current_time[31:0]
// rsp       out        rsp_valid/rsp_ready  rsp_level[7:0], rsp_stepped,
//                                           rsp_blink_active, rsp_blink_level
// csr       in/out     psel/penable/pready  paddr[3:0], pwdata/prdata[31:0]
//
// one item a cycle sustained while rsp_ready is high; an item passes the input register, then the output register
// the ramp and blink state loops close within the compute stage
// synchronous reset clears the valid flags and the ramp and blink state, the config registers take their default values
// a stalled result holds in the output register while the input register
// still takes one more item, then req_ready drops until rsp_ready returns
module status_led_fade_and_blink_code_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // update items
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [slfbc_pkg::STAMP_BITS-1:0]       req_current_time,
   // result items
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [slfbc_pkg::LEVEL_BITS-1:0]       rsp_level,
   output logic                                   rsp_stepped,
   output logic                                   rsp_blink_active,
   output logic                                   rsp_blink_level,
   // register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [slfbc_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [slfbc_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [slfbc_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                   pready
);

   // ---------------------------------------------------------------- registers
   slfbc_pkg::cfg_type         cfg_ff, cfg_in;
   slfbc_pkg::reg_index_type   reg_index;
   logic                       csr_write;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            slfbc_pkg::REG_STEP_TIME:
               cfg_in.step_time = pwdata[slfbc_pkg::STEP_BITS-1:0];
            slfbc_pkg::REG_MAX_BRIGHTNESS:
               cfg_in.max_brightness = pwdata[slfbc_pkg::LEVEL_BITS-1:0];
            slfbc_pkg::REG_BLINK_CODE:
               cfg_in.blink_code = pwdata[slfbc_pkg::CODE_BITS-1:0];
            slfbc_pkg::REG_TOGGLE_TIME:
               cfg_in.toggle_time = pwdata[slfbc_pkg::TOGGLE_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_time      <= slfbc_pkg::STEP_TIME_RESET;
         cfg_ff.max_brightness <= slfbc_pkg::MAX_BRIGHTNESS_RESET;
         cfg_ff.blink_code     <= slfbc_pkg::BLINK_CODE_RESET;
         cfg_ff.toggle_time    <= slfbc_pkg::TOGGLE_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, zero extended
   always_comb begin
      unique case (reg_index)
         slfbc_pkg::REG_STEP_TIME:
            prdata = slfbc_pkg::CSR_DATA_BITS'(cfg_ff.step_time);
         slfbc_pkg::REG_MAX_BRIGHTNESS:
            prdata = slfbc_pkg::CSR_DATA_BITS'(cfg_ff.max_brightness);
         slfbc_pkg::REG_BLINK_CODE:
            prdata = slfbc_pkg::CSR_DATA_BITS'(cfg_ff.blink_code);
         slfbc_pkg::REG_TOGGLE_TIME:
            prdata = slfbc_pkg::CSR_DATA_BITS'(cfg_ff.toggle_time);
         default: prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ input stage
   logic                             in_valid_ff;
   logic [slfbc_pkg::TIME_BITS-1:0]  in_time_ff;
   logic [slfbc_pkg::WIDE_BITS-1:0]  time_wide;
   logic                             out_valid_ff;
   logic                             advance;

   // compute stage fires when the output register is free or being emptied
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   // time stamp widened to WIDE_BITS; the input register keeps the low TIME_BITS
   assign time_wide = slfbc_pkg::WIDE_BITS'(req_current_time);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_time_ff <= time_wide[slfbc_pkg::TIME_BITS-1:0];
      end
   end

   // ---------------------------------------------------------- compute stage
   logic [slfbc_pkg::LEVEL_BITS-1:0] level_in;
   logic                             stepped_in;
   logic                             active_in;
   logic                             blink_level_in;

   slfbc_ramp u_ramp (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .now     (in_time_ff),
      .cfg     (cfg_ff),
      .level   (level_in),
      .stepped (stepped_in)
   );

   slfbc_blink u_blink (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .now         (in_time_ff),
      .cfg         (cfg_ff),
      .active      (active_in),
      .blink_level (blink_level_in)
   );

   // ----------------------------------------------------------- output stage
   logic [slfbc_pkg::LEVEL_BITS-1:0] rsp_level_ff;
   logic                             rsp_stepped_ff;
   logic                             rsp_active_ff;
   logic                             rsp_blink_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_level_ff   <= level_in;
         rsp_stepped_ff <= stepped_in;
         rsp_active_ff  <= active_in;
         rsp_blink_ff   <= blink_level_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_level        = rsp_level_ff;
   assign rsp_stepped      = rsp_stepped_ff;
   assign rsp_blink_active = rsp_active_ff;
   assign rsp_blink_level  = rsp_blink_ff;

endmodule

### rtl/core/slfbc_checker.sv
`include "status_led_fade_and_blink_code_unit_defines.svh"

module slfbc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [slfbc_pkg::LEVEL_BITS-1:0]    rsp_level,
   input logic                                rsp_stepped,
   input logic                                rsp_blink_active,
   input logic                                rsp_blink_level
);

   // a stalled result holds
   `SLFBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_level) && $stable(rsp_stepped) && $stable(rsp_blink_active) && $stable(rsp_blink_level))

   // input side only backs up behind a stalled result
   `SLFBC_ASSERT_NOW(a_ready_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // pin level is low in fade mode
   `SLFBC_ASSERT_NOW(a_fade_pin, clock, reset, rsp_valid && !rsp_blink_active, !rsp_blink_level)

   // reset empties both stages
   `SLFBC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && req_ready)

endmodule

bind status_led_fade_and_blink_code_unit slfbc_checker u_slfbc_checker (.*);
